/* hdl/assert_macros.svh */
// assertion macros used by the checker file
// depends on clk and rst being visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define GBN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gbn assertion failed");

// checked on every edge, reset included
`define GBN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gbn assertion failed");

`endif

/* hdl/gbn_pkg.sv */
// types and constants for the go-back-n sender window
// no dependencies
package gbn_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int SEQ_BITS   = 16;
  localparam int WIN_W      = 6;
  localparam int TMO_W      = 16;
  localparam int ACK_W      = SEQ_BITS + 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int CQ_DEPTH   = 2;
  localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W   = $clog2(CQ_DEPTH + 1);
  localparam int REG_IDX_W  = 2;
  localparam int REG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_WIN_LIMIT     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TOTAL_FRAMES  = 2'd2;

  localparam logic [WIN_W-1:0]    WIN_LIMIT_RST     = 6'd8;
  localparam logic [TMO_W-1:0]    TIMEOUT_TICKS_RST = 16'd100;
  localparam logic [SEQ_BITS-1:0] TOTAL_FRAMES_RST  = 16'd1;
  localparam logic [TMO_W-1:0]    TIMER_MAX         = '1;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_ACK   = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_ACK,
    CMD_START,
    CMD_NOP
  } cmd_kind_t;

  // classified request passed from front to back
  typedef struct packed {
    cmd_kind_t           kind;
    logic                ack_neg;
    logic [SEQ_BITS-1:0] ack_val;
    logic [SEQ_BITS:0]   ack_inc;
  } cmd_t;

  typedef struct packed {
    logic [WIN_W-1:0]    win_limit;
    logic [TMO_W-1:0]    timeout_ticks;
    logic [SEQ_BITS-1:0] total_frames;
  } cfg_t;

  typedef struct packed {
    logic                frame_valid;
    logic [SEQ_BITS-1:0] frame_seq;
    logic                timed_out;
    logic [SEQ_BITS-1:0] window_base;
    logic                done_res;
    logic                last_of_run;
  } res_t;

  // status of the command queue: valid for its consumer, full for its producer
  typedef struct packed {
    logic valid;
    logic full;
  } cq_status_t;

endpackage

/* hdl/gbn_front.sv */
// front end: takes requests, decodes the action and precomputes ack + 1
// depends on gbn_pkg
module gbn_front import gbn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              action,
  input  logic signed [ACK_W-1:0] ack_seq,
  input  logic                    cq_full,
  output logic                    cq_push,
  output cmd_t                    cq_cmd
);

  logic fr_valid;
  cmd_t fr_cmd;
  cmd_t dec_cmd;
  logic accept;
  logic drain;

  always_comb begin
    dec_cmd.ack_neg = ack_seq[ACK_W-1];
    dec_cmd.ack_val = ack_seq[SEQ_BITS-1:0];
    dec_cmd.ack_inc = {1'b0, ack_seq[SEQ_BITS-1:0]} + {{SEQ_BITS{1'b0}}, 1'b1};
    case (action)
      ACT_TICK:  dec_cmd.kind = CMD_TICK;
      ACT_ACK:   dec_cmd.kind = CMD_ACK;
      ACT_START: dec_cmd.kind = CMD_START;
      default:   dec_cmd.kind = CMD_NOP;
    endcase
  end

  assign full    = fr_valid && cq_full;
  assign accept  = push && !full;
  assign drain   = fr_valid && !cq_full;
  assign cq_push = drain;
  assign cq_cmd  = fr_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else begin
      fr_valid <= accept || (fr_valid && !drain);
    end
    if (accept) begin
      fr_cmd <= dec_cmd;
    end
  end

endmodule

/* hdl/gbn_cmd_fifo.sv */
// short request queue between the front end and the window engine
// depends on gbn_pkg
module gbn_cmd_fifo import gbn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  cmd_t       wr_cmd,
  input  logic       rd,
  output cmd_t       rd_cmd,
  output cq_status_t status
);

  cmd_t                slots [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign status.valid = (count != '0);
  assign status.full  = (count == CQ_CNT_W'(CQ_DEPTH));
  assign do_wr        = wr && !status.full;
  assign do_rd        = rd && status.valid;
  assign rd_cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

/* hdl/gbn_back.sv */
// window engine: applies requests to base, next and the timer, emits results
// depends on gbn_pkg
module gbn_back import gbn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  cq_status_t cq_status,
  input  cmd_t       cq_cmd,
  output logic       cq_pop,
  output logic       res_valid,
  output res_t       res,
  input  logic       res_take
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEND,
    ST_TIMER,
    ST_STATUS
  } state_t;

  state_t              state;
  cmd_t                cur;
  logic [SEQ_BITS-1:0] base_frame;
  logic [SEQ_BITS-1:0] next_frame;
  logic [TMO_W-1:0]    elapsed_ticks;
  logic [CNT_W-1:0]    sent;
  logic                tmo;

  logic [WIN_W-1:0]    eff_win;
  logic [SEQ_BITS:0]   wend;
  logic                can_send;
  logic                out_free;
  logic                res_load;
  logic [SEQ_BITS:0]   nb_raw;
  logic [SEQ_BITS-1:0] nb;
  logic [TMO_W-1:0]    elapsed_inc;
  logic                done_now;

  always_comb begin
    eff_win = cfg.win_limit;
    if (cfg.win_limit == '0) begin
      eff_win = WIN_W'(1);
    end else if (cfg.win_limit > WIN_W'(MAX_WINDOW)) begin
      eff_win = WIN_W'(MAX_WINDOW);
    end
  end

  assign wend     = {1'b0, base_frame} + {{(SEQ_BITS + 1 - WIN_W){1'b0}}, eff_win};
  assign can_send = ({1'b0, next_frame} < wend) && (next_frame < cfg.total_frames)
                    && (sent < CNT_W'(MAX_WINDOW));
  assign out_free = !res_valid || res_take;
  assign res_load = out_free && (((state == ST_SEND) && can_send) || (state == ST_STATUS));
  assign cq_pop   = (state == ST_IDLE) && cq_status.valid;
  assign done_now = (base_frame >= cfg.total_frames);

  // clamp the new base to the frame total
  assign nb_raw = (cur.ack_inc > {1'b0, cfg.total_frames}) ? {1'b0, cfg.total_frames}
                                                            : cur.ack_inc;
  assign nb     = nb_raw[SEQ_BITS-1:0];

  assign elapsed_inc = (elapsed_ticks < TIMER_MAX) ? elapsed_ticks + 1'b1 : elapsed_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      base_frame    <= '0;
      next_frame    <= '0;
      elapsed_ticks <= '0;
      res_valid     <= 1'b0;
      sent          <= '0;
      tmo           <= 1'b0;
    end else begin
      res_valid <= res_load || (res_valid && !res_take);
      case (state)
        ST_IDLE: begin
          if (cq_status.valid) begin
            cur   <= cq_cmd;
            sent  <= '0;
            tmo   <= 1'b0;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (cur.kind)
            CMD_START: begin
              base_frame    <= '0;
              next_frame    <= '0;
              elapsed_ticks <= '0;
              state         <= ST_STATUS;
            end
            CMD_ACK: begin
              if (!cur.ack_neg && cur.ack_val >= base_frame) begin
                base_frame <= nb;
                if (next_frame < nb) begin
                  next_frame <= nb;
                end
              end
              state <= ST_STATUS;
            end
            CMD_TICK: begin
              state <= ST_SEND;
            end
            default: begin
              state <= ST_STATUS;
            end
          endcase
        end
        ST_SEND: begin
          if (!can_send) begin
            state <= ST_TIMER;
          end else if (out_free) begin
            res.frame_valid <= 1'b1;
            res.frame_seq   <= next_frame;
            res.timed_out   <= 1'b0;
            res.window_base <= base_frame;
            res.done_res    <= done_now;
            res.last_of_run <= 1'b0;
            next_frame      <= next_frame + 1'b1;
            sent            <= sent + 1'b1;
          end
        end
        ST_TIMER: begin
          state <= ST_STATUS;
          if (elapsed_inc > cfg.timeout_ticks) begin
            if (base_frame < next_frame) begin
              next_frame <= base_frame;
              tmo        <= 1'b1;
            end
            elapsed_ticks <= '0;
          end else if (base_frame >= next_frame) begin
            elapsed_ticks <= '0;
          end else begin
            elapsed_ticks <= elapsed_inc;
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            res.frame_valid <= 1'b0;
            res.frame_seq   <= next_frame;
            res.timed_out   <= tmo;
            res.window_base <= base_frame;
            res.done_res    <= done_now;
            res.last_of_run <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/go_back_n_sender_window_core.sv */
// go-back-n sender window, top level: config registers, front end, queue, engine
// depends on gbn_pkg, gbn_front, gbn_cmd_fifo, gbn_back
//
//   channel   handshake         payload
//   request   push / full       action, ack_seq
//   result    pop / empty       frame_valid, frame_seq, timed_out, window_base,
//                               done_res, last_of_run
//   config    wr_en             wr_index, wr_data
//
// start, ack and other actions pass the front register, request queue and engine states
// idle, exec and status, which shows their status result; a tick passes idle, exec, send
// (up to 32 frames, one frame per cycle while results are taken), timer and status. the
// front end and a 2-entry request queue absorb up to three requests while the engine
// works. a stalled pop holds the engine at its next result. reset is synchronous.
module go_back_n_sender_window_core import gbn_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                action,
  input  logic signed [ACK_W-1:0]   ack_seq,
  output logic                      empty,
  input  logic                      pop,
  output logic                      frame_valid,
  output logic [SEQ_BITS-1:0]       frame_seq,
  output logic                      timed_out,
  output logic [SEQ_BITS-1:0]       window_base,
  output logic                      done_res,
  output logic                      last_of_run,
  input  logic                      wr_en,
  input  logic [REG_IDX_W-1:0]      wr_index,
  input  logic [REG_DATA_W-1:0]     wr_data
);

  cfg_t       cfg;
  cq_status_t cq_status;
  cmd_t       fr_cmd;
  cmd_t       cq_cmd;
  logic       cq_push;
  logic       cq_pop;
  logic       res_valid;
  res_t       res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_limit     <= WIN_LIMIT_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
      cfg.total_frames  <= TOTAL_FRAMES_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_WIN_LIMIT:     cfg.win_limit     <= wr_data[WIN_W-1:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= wr_data[TMO_W-1:0];
        REG_TOTAL_FRAMES:  cfg.total_frames  <= wr_data[SEQ_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  gbn_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .action  (action),
    .ack_seq (ack_seq),
    .cq_full (cq_status.full),
    .cq_push (cq_push),
    .cq_cmd  (fr_cmd)
  );

  gbn_cmd_fifo u_cq (
    .clk    (clk),
    .rst    (rst),
    .wr     (cq_push),
    .wr_cmd (fr_cmd),
    .rd     (cq_pop),
    .rd_cmd (cq_cmd),
    .status (cq_status)
  );

  gbn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cq_status (cq_status),
    .cq_cmd    (cq_cmd),
    .cq_pop    (cq_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (pop)
  );

  assign empty       = !res_valid;
  assign frame_valid = res.frame_valid;
  assign frame_seq   = res.frame_seq;
  assign timed_out   = res.timed_out;
  assign window_base = res.window_base;
  assign done_res    = res.done_res;
  assign last_of_run = res.last_of_run;

endmodule

/* hdl/gbn_checker.sv */
// port-level checks on the go-back-n sender window, bound to the top level
// depends on gbn_pkg and assert_macros.svh
`include "assert_macros.svh"

module gbn_checker import gbn_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                empty,
  input logic                pop,
  input logic                frame_valid,
  input logic [SEQ_BITS-1:0] frame_seq,
  input logic                timed_out,
  input logic [SEQ_BITS-1:0] window_base,
  input logic                last_of_run
);

  // nothing waits on the result side straight after reset
  `GBN_ASSERT_ALWAYS(a_empty_after_rst, rst |=> empty)

  // a result that is not taken stays valid and keeps its frame_seq
  `GBN_ASSERT(a_hold_on_stall, (!empty && !pop) |=> (!empty && $stable(frame_seq)))

  // frame orders never close a request and never flag a timeout
  `GBN_ASSERT(a_frame_not_last, (!empty && frame_valid) |-> (!last_of_run && !timed_out))

  // frames are never ordered from below the window base
  `GBN_ASSERT(a_frame_in_window, (!empty && frame_valid) |-> (frame_seq >= window_base))

endmodule

bind go_back_n_sender_window_core gbn_checker u_gbn_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .frame_valid (frame_valid),
  .frame_seq   (frame_seq),
  .timed_out   (timed_out),
  .window_base (window_base),
  .last_of_run (last_of_run)
);
